/* hdl/fcss_pkg.sv */
// Shared types and constants for the FAT12 chain sector sequencer.
`timescale 1ns / 1ps

package fcss_pkg;

    // Default allocation table store size in bytes
    localparam int unsigned TABLE_BYTES_DEFAULT = 8192;

    // Request modes
    localparam logic [1:0] MODE_WRITE_BYTE = 2'd0;
    localparam logic [1:0] MODE_OPEN_CHAIN = 2'd1;
    localparam logic [1:0] MODE_OPEN_ROOT  = 2'd2;
    localparam logic [1:0] MODE_ADVANCE    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SECTORS_PER_CLUSTER = 2'd0;
    localparam logic [1:0] CFG_DATA_START_SECTOR   = 2'd1;
    localparam logic [1:0] CFG_ROOT_START_SECTOR   = 2'd2;

    // Table entry constants
    localparam logic [11:0] END_MARK      = 12'hFF8;
    localparam logic [11:0] ENTRY_MASK    = 12'hFFF;
    localparam logic [12:0] CLUSTER_BASE  = 13'd2;
    localparam logic [7:0]  MAX_SPC       = 8'd128;
    localparam logic [7:0]  UNUSED_BYTE   = 8'hFF;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_RD_DONE,
        ST_LOCATE,
        ST_MUL,
        ST_ADD,
        ST_EMIT
    } state_t;

endpackage

/* hdl/fat12_chain_sector_sequencer_core.sv */
// FAT12 chain sector sequencer: table store, chain walk sequencer and sector math.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. A table byte write
// (mode 0) gives no result and leaves busy low, so the next request can be
// taken at the following edge. Every other request raises busy until its
// result cycle ends. Opening the root region, advancing inside it, or
// advancing an ended chain holds busy only through the result cycle. Opening
// a chain or advancing within a cluster passes through the end check,
// multiply, add and result states. An advance that wraps into the next
// cluster first fetches the 12-bit entry as two bytes through the single read
// port of the byte-wide table store, then goes through the states above. When
// the cluster reached is an end marker, the multiply and add are skipped.
// The result is on the output ports for exactly one cycle, marked by done,
// and the receiver cannot hold it off. Configuration writes take effect at
// once and are to be made only while the block is idle.
module fat12_chain_sector_sequencer_core #(
    parameter int unsigned TABLE_BYTES = fcss_pkg::TABLE_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [12:0] table_address,
    input  logic [7:0]  table_byte,
    input  logic [11:0] first_cluster,
    // result
    output logic        done,
    output logic [31:0] sector_address,
    output logic [11:0] cluster_now,
    output logic [6:0]  sector_in_cluster_now,
    output logic        end_of_chain
);

    localparam int unsigned AW = $clog2(TABLE_BYTES);
    localparam logic [13:0] TABLE_LIMIT = 14'(TABLE_BYTES);

    fcss_pkg::state_t state_reg, state_next;

    // configuration
    logic [7:0]  spc_reg;
    logic [31:0] data_start_reg;
    logic [31:0] root_start_reg;

    // walk state
    logic [11:0] cluster_reg, cluster_next;
    logic [6:0]  offset_reg, offset_next;
    logic [31:0] linear_reg, linear_next;
    logic        root_reg, root_next;
    logic        ended_reg, ended_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  lo_byte_reg, lo_byte_next;

    // table store
    logic [7:0]  table_mem [TABLE_BYTES];
    logic [7:0]  rd_data_reg;
    logic        rd_oob_reg;
    logic        rd_en;
    logic        rd_oob;
    logic [13:0] rd_index;
    logic        wr_en;

    logic        accept;
    logic [13:0] entry_index;
    logic [7:0]  byte_val;
    logic [15:0] entry_word;
    logic [11:0] entry;
    logic [7:0]  eff_spc;
    logic [7:0]  offset_inc;
    logic [31:0] diff32;
    logic [39:0] mul_wide;

    assign accept = start && !busy;

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg        <= 8'd1;
            data_start_reg <= 32'd0;
            root_start_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fcss_pkg::CFG_SECTORS_PER_CLUSTER: spc_reg        <= cfg_data[7:0];
                fcss_pkg::CFG_DATA_START_SECTOR:   data_start_reg <= cfg_data;
                fcss_pkg::CFG_ROOT_START_SECTOR:   root_start_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Index of the packed entry: cluster * 3 / 2
    assign entry_index = {2'b00, cluster_reg} + {3'b000, cluster_reg[11:1]};

    // Pick the table byte for each fetch cycle
    always_comb
    begin
        rd_index = entry_index;
        if (state_reg == fcss_pkg::ST_RD_HI)
        begin
            rd_index = entry_index + 14'd1;
        end
        rd_oob = (rd_index >= TABLE_LIMIT);
        rd_en  = ((state_reg == fcss_pkg::ST_RD_LO) || (state_reg == fcss_pkg::ST_RD_HI))
                 && !rd_oob;
    end

    assign wr_en = accept && (mode == fcss_pkg::MODE_WRITE_BYTE)
                   && ({1'b0, table_address} < TABLE_LIMIT);

    // Write and read the table store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[table_address[AW-1:0]] <= table_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_index[AW-1:0]];
        end
    end

    // Track bytes that lie beyond the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_oob_reg <= 1'b0;
        end
        else
        begin
            rd_oob_reg <= rd_oob;
        end
    end

    assign byte_val   = rd_oob_reg ? fcss_pkg::UNUSED_BYTE : rd_data_reg;
    assign entry_word = {byte_val, lo_byte_reg};
    assign entry      = cluster_reg[0] ? (entry_word[15:4] & fcss_pkg::ENTRY_MASK)
                                       : (entry_word[11:0] & fcss_pkg::ENTRY_MASK);

    // Clamp the cluster size used for wrap
    always_comb
    begin
        if (spc_reg == 8'd0)
        begin
            eff_spc = 8'd1;
        end
        else if (spc_reg > fcss_pkg::MAX_SPC)
        begin
            eff_spc = fcss_pkg::MAX_SPC;
        end
        else
        begin
            eff_spc = spc_reg;
        end
    end

    assign offset_inc = {1'b0, offset_reg} + 8'd1;

    // Sign-extended (cluster - 2) times the raw cluster size, modulo 2^32
    always_comb
    begin
        logic [12:0] diff13;
        diff13   = {1'b0, cluster_reg} - fcss_pkg::CLUSTER_BASE;
        diff32   = {{19{diff13[12]}}, diff13};
        mul_wide = 40'(diff32) * 40'(spc_reg);
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        fcss_pkg::MODE_WRITE_BYTE: state_next = fcss_pkg::ST_IDLE;
                        fcss_pkg::MODE_OPEN_CHAIN: state_next = fcss_pkg::ST_LOCATE;
                        fcss_pkg::MODE_OPEN_ROOT:  state_next = fcss_pkg::ST_EMIT;
                        fcss_pkg::MODE_ADVANCE:
                        begin
                            if (root_reg || ended_reg)
                            begin
                                state_next = fcss_pkg::ST_EMIT;
                            end
                            else if (offset_inc >= eff_spc)
                            begin
                                state_next = fcss_pkg::ST_RD_LO;
                            end
                            else
                            begin
                                state_next = fcss_pkg::ST_LOCATE;
                            end
                        end
                        default: state_next = fcss_pkg::ST_IDLE;
                    endcase
                end
            end
            fcss_pkg::ST_RD_LO:   state_next = fcss_pkg::ST_RD_HI;
            fcss_pkg::ST_RD_HI:   state_next = fcss_pkg::ST_RD_DONE;
            fcss_pkg::ST_RD_DONE: state_next = fcss_pkg::ST_LOCATE;
            fcss_pkg::ST_LOCATE:
            begin
                if ((cluster_reg >= fcss_pkg::END_MARK) || ended_reg)
                begin
                    state_next = fcss_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = fcss_pkg::ST_MUL;
                end
            end
            fcss_pkg::ST_MUL:  state_next = fcss_pkg::ST_ADD;
            fcss_pkg::ST_ADD:  state_next = fcss_pkg::ST_EMIT;
            fcss_pkg::ST_EMIT: state_next = fcss_pkg::ST_IDLE;
            default:           state_next = fcss_pkg::ST_IDLE;
        endcase
    end

    // Update the walk state
    always_comb
    begin
        cluster_next = cluster_reg;
        offset_next  = offset_reg;
        linear_next  = linear_reg;
        root_next    = root_reg;
        ended_next   = ended_reg;
        acc_next     = acc_reg;
        lo_byte_next = lo_byte_reg;
        unique case (state_reg)
            fcss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        fcss_pkg::MODE_WRITE_BYTE: ;
                        fcss_pkg::MODE_OPEN_CHAIN:
                        begin
                            root_next    = 1'b0;
                            ended_next   = 1'b0;
                            cluster_next = first_cluster & fcss_pkg::ENTRY_MASK;
                            offset_next  = 7'd0;
                        end
                        fcss_pkg::MODE_OPEN_ROOT:
                        begin
                            root_next    = 1'b1;
                            ended_next   = 1'b0;
                            cluster_next = 12'd0;
                            offset_next  = 7'd0;
                            linear_next  = root_start_reg;
                        end
                        fcss_pkg::MODE_ADVANCE:
                        begin
                            if (root_reg)
                            begin
                                linear_next = linear_reg + 32'd1;
                            end
                            else if (!ended_reg)
                            begin
                                if (offset_inc >= eff_spc)
                                begin
                                    offset_next = 7'd0;
                                end
                                else
                                begin
                                    offset_next = offset_inc[6:0];
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            fcss_pkg::ST_RD_HI:   lo_byte_next = byte_val;
            fcss_pkg::ST_RD_DONE: cluster_next = entry;
            fcss_pkg::ST_LOCATE:
            begin
                if (cluster_reg >= fcss_pkg::END_MARK)
                begin
                    ended_next = 1'b1;
                end
            end
            fcss_pkg::ST_MUL: acc_next    = mul_wide[31:0] + data_start_reg;
            fcss_pkg::ST_ADD: linear_next = acc_reg + {25'd0, offset_reg};
            default: ;
        endcase
    end

    // Hold state and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fcss_pkg::ST_IDLE;
            cluster_reg <= 12'd0;
            offset_reg  <= 7'd0;
            linear_reg  <= 32'd0;
            root_reg    <= 1'b0;
            ended_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cluster_reg <= cluster_next;
            offset_reg  <= offset_next;
            linear_reg  <= linear_next;
            root_reg    <= root_next;
            ended_reg   <= ended_next;
        end
    end

    // Datapath scratch registers
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        lo_byte_reg <= lo_byte_next;
    end

    // Drive handshake and result ports
    always_comb
    begin
        busy                  = (state_reg != fcss_pkg::ST_IDLE);
        done                  = 1'b0;
        sector_address        = 32'd0;
        cluster_now           = 12'd0;
        sector_in_cluster_now = 7'd0;
        end_of_chain          = 1'b0;
        unique case (state_reg)
            fcss_pkg::ST_EMIT:
            begin
                done = 1'b1;
                if (root_reg)
                begin
                    sector_address = linear_reg;
                end
                else
                begin
                    sector_address        = ended_reg ? 32'd0 : linear_reg;
                    cluster_now           = cluster_reg;
                    sector_in_cluster_now = offset_reg;
                    end_of_chain          = ended_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

/* tb/sv/fat12_chain_sector_sequencer_core_tb.sv */
// Self-checking testbench for the FAT12 chain sector sequencer core.
`timescale 1ns / 1ps

module fat12_chain_sector_sequencer_core_tb;

    localparam int unsigned FAT_BYTES    = fcss_pkg::TABLE_BYTES_DEFAULT;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned PHASE_ITEMS  = 140;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam int unsigned MAX_REPORTS  = 40;

    typedef struct packed {
        logic [1:0]  mode;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [11:0] clust;
    } fat_req_t;

    typedef struct packed {
        logic [31:0] sector;
        logic [11:0] cluster;
        logic [6:0]  offset;
        logic        eoc;
    } sector_res_t;

    typedef struct packed {
        fat_req_t    req;
        logic        typed;
        sector_res_t want;
    } vector_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [12:0] table_address;
    logic [7:0]  table_byte;
    logic [11:0] first_cluster;
    logic        done;
    logic [31:0] sector_address;
    logic [11:0] cluster_now;
    logic [6:0]  sector_in_cluster_now;
    logic        end_of_chain;

    // Mirror of the allocation table and of the walk state
    logic [7:0]  fat_mirror [FAT_BYTES];
    bit          fat_known  [FAT_BYTES];
    logic [11:0] cur_cluster = '0;
    logic [6:0]  cur_offset = '0;
    logic [31:0] lin_sector = '0;
    logic        in_root = 1'b0;
    logic        chain_done = 1'b0;
    logic [7:0]  spc_reg = 8'd1;
    logic [31:0] data_start_reg = '0;
    logic [31:0] root_start_reg = '0;

    sector_res_t pending_sectors [$];
    vector_row_t directed_rows [$];

    int mismatches = 0;
    int n_requests = 0;
    int n_checked = 0;
    int n_ended = 0;
    int cycles = 0;
    int idle_pct = 0;

    fat12_chain_sector_sequencer_core #(
        .TABLE_BYTES(FAT_BYTES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .mode(mode),
        .table_address(table_address),
        .table_byte(table_byte),
        .first_cluster(first_cluster),
        .done(done),
        .sector_address(sector_address),
        .cluster_now(cluster_now),
        .sector_in_cluster_now(sector_in_cluster_now),
        .end_of_chain(end_of_chain)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Read a table byte; bytes past the store read as unused
    function automatic logic [7:0] fat_byte(input int unsigned a);
        if (a >= FAT_BYTES)
            return fcss_pkg::UNUSED_BYTE;
        return fat_mirror[a];
    endfunction

    // Unpack the 12-bit entry of a cluster from its two bytes
    function automatic logic [11:0] fat_entry(input logic [11:0] cl);
        int unsigned idx;
        logic [15:0] word;
        idx = cl * 3 / 2;
        word = {fat_byte(idx + 1), fat_byte(idx)};
        if (cl[0])
            return word[15:4];
        return word[11:0];
    endfunction

    // Sectors walked before following the chain
    function automatic int unsigned spc_wrap();
        if (spc_reg == 8'd0)
            return 1;
        if (spc_reg > fcss_pkg::MAX_SPC)
            return fcss_pkg::MAX_SPC;
        return spc_reg;
    endfunction

    // Flag the end marker, else map cluster and offset to a disk sector
    function automatic void locate_sector();
        logic [31:0] rel;
        if (cur_cluster >= fcss_pkg::END_MARK)
            chain_done = 1'b1;
        if (!chain_done)
        begin
            rel = {20'd0, cur_cluster} - {19'd0, fcss_pkg::CLUSTER_BASE};
            lin_sector = data_start_reg + rel * {24'd0, spc_reg} + {25'd0, cur_offset};
        end
    endfunction

    // Apply one request to the mirror; return 1 when it yields a sector result
    function automatic logic step_sequencer(input fat_req_t r, output sector_res_t res);
        logic has_result;
        has_result = 1'b1;
        res = '0;
        case (r.mode)
            fcss_pkg::MODE_WRITE_BYTE:
            begin
                if (r.addr < FAT_BYTES)
                begin
                    fat_mirror[r.addr] = r.data;
                    fat_known[r.addr] = 1'b1;
                end
                has_result = 1'b0;
            end
            fcss_pkg::MODE_OPEN_CHAIN:
            begin
                in_root = 1'b0;
                chain_done = 1'b0;
                cur_cluster = r.clust;
                cur_offset = '0;
                locate_sector();
            end
            fcss_pkg::MODE_OPEN_ROOT:
            begin
                in_root = 1'b1;
                chain_done = 1'b0;
                cur_cluster = '0;
                cur_offset = '0;
                lin_sector = root_start_reg;
            end
            default:
            begin
                if (in_root)
                    lin_sector = lin_sector + 32'd1;
                else if (!chain_done)
                begin
                    if (cur_offset + 1 >= spc_wrap())
                    begin
                        cur_offset = '0;
                        cur_cluster = fat_entry(cur_cluster);
                    end
                    else
                        cur_offset = cur_offset + 7'd1;
                    locate_sector();
                end
            end
        endcase
        if (in_root)
            res.sector = lin_sector;
        else
        begin
            res.sector = chain_done ? 32'd0 : lin_sector;
            res.cluster = cur_cluster;
            res.offset = cur_offset;
            res.eoc = chain_done;
        end
        return has_result;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < MAX_REPORTS)
            $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Random filler in every field; callers set the fields the mode uses
    function automatic fat_req_t random_req(input logic [1:0] m);
        fat_req_t r;
        r.mode = m;
        r.addr = 13'($urandom);
        r.data = 8'($urandom);
        r.clust = 12'($urandom);
        return r;
    endfunction

    // Drive one request, hold it until accepted, then record its expectation
    task automatic issue_request(input fat_req_t r, input logic typed, input sector_res_t want);
        sector_res_t pred;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        mode <= r.mode;
        table_address <= r.addr;
        table_byte <= r.data;
        first_cluster <= r.clust;
        do
            @(posedge clk);
        while (busy);
        n_requests++;
        if (step_sequencer(r, pred))
            pending_sectors.push_back(typed ? want : pred);
    endtask

    task automatic put_byte(input int unsigned a, input logic [7:0] d);
        fat_req_t r;
        r = random_req(fcss_pkg::MODE_WRITE_BYTE);
        r.addr = 13'(a);
        r.data = d;
        issue_request(r, 1'b0, '0);
    endtask

    // Fill unwritten entry bytes before an advance that follows the chain
    task automatic run_request(input fat_req_t r, input logic typed, input sector_res_t want);
        int unsigned idx;
        if (r.mode == fcss_pkg::MODE_ADVANCE && !in_root && !chain_done
            && cur_offset + 1 >= spc_wrap())
        begin
            idx = cur_cluster * 3 / 2;
            for (int k = 0; k < 2; k++)
                if (idx + k < FAT_BYTES && !fat_known[idx + k])
                    put_byte(idx + k, 8'($urandom_range(255)));
        end
        issue_request(r, typed, want);
    endtask

    // Link a cluster to a new entry with two byte writes
    task automatic set_entry(input logic [11:0] cl, input logic [11:0] value);
        int unsigned idx;
        logic [7:0] lo;
        logic [7:0] hi;
        idx = cl * 3 / 2;
        if (!cl[0])
        begin
            lo = value[7:0];
            hi = {fat_mirror[idx + 1][7:4], value[11:8]};
        end
        else
        begin
            lo = {value[3:0], fat_mirror[idx][3:0]};
            hi = value[11:4];
        end
        put_byte(idx, lo);
        put_byte(idx + 1, hi);
    endtask

    // Mostly short hops, some end markers, some anywhere
    function automatic logic [11:0] pick_link();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 60)
            return 12'($urandom_range(2, 63));
        if (p < 85)
            return fcss_pkg::END_MARK + 12'($urandom_range(7));
        return 12'($urandom);
    endfunction

    // Drop start and wait until every sector result has arrived
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_sectors.size() != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] spc, input logic [31:0] dstart,
                               input logic [31:0] rstart);
        cfg_write <= 1'b1;
        cfg_index <= fcss_pkg::CFG_SECTORS_PER_CLUSTER;
        cfg_data <= {24'd0, spc};
        @(posedge clk);
        cfg_index <= fcss_pkg::CFG_DATA_START_SECTOR;
        cfg_data <= dstart;
        @(posedge clk);
        cfg_index <= fcss_pkg::CFG_ROOT_START_SECTOR;
        cfg_data <= rstart;
        @(posedge clk);
        cfg_write <= 1'b0;
        spc_reg = spc;
        data_start_reg = dstart;
        root_start_reg = rstart;
    endtask

    task automatic add_row(input logic [1:0] m, input logic [12:0] a, input logic [7:0] d,
                           input logic [11:0] c, input logic typed, input logic [31:0] s,
                           input logic [11:0] cl, input logic [6:0] off, input logic eoc);
        vector_row_t row;
        row.req = '{mode: m, addr: a, data: d, clust: c};
        row.typed = typed;
        row.want = '{sector: s, cluster: cl, offset: off, eoc: eoc};
        directed_rows.push_back(row);
    endtask

    // Check each sector result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        sector_res_t want;
        if (rst_n && done)
        begin
            if (pending_sectors.size() == 0)
                flag_mismatch("result with no request pending", sector_address, '0);
            else
            begin
                want = pending_sectors.pop_front();
                n_checked++;
                if (sector_address !== want.sector)
                    flag_mismatch("sector_address", sector_address, want.sector);
                if (cluster_now !== want.cluster)
                    flag_mismatch("cluster_now", 32'(cluster_now), 32'(want.cluster));
                if (sector_in_cluster_now !== want.offset)
                    flag_mismatch("sector_in_cluster_now", 32'(sector_in_cluster_now),
                                  32'(want.offset));
                if (end_of_chain !== want.eoc)
                    flag_mismatch("end_of_chain", 32'(end_of_chain), 32'(want.eoc));
            end
            if (end_of_chain === 1'b1)
                n_ended++;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        fat_req_t    r;
        int unsigned pick;
        logic [11:0] lc;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        start <= 1'b0;
        mode <= fcss_pkg::MODE_WRITE_BYTE;
        table_address <= '0;
        table_byte <= '0;
        first_cluster <= '0;
        for (int i = 0; i < FAT_BYTES; i++)
            fat_mirror[i] = 8'd0;

        // Chain 0 -> 3 -> 4 -> end, read at reset settings (one sector, base 0)
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'd0, 8'h03, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'd1, 8'h00, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'd2, 8'h00, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'd3, 8'h00, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'd4, 8'h40, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'd5, 8'h00, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'd6, 8'hFF, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'd7, 8'h0F, 12'd0, 1'b0, 0, 0, 0, 0);
        // advance before any open walks from cluster 0
        add_row(fcss_pkg::MODE_ADVANCE, 13'd0, 8'd0, 12'd0, 1'b1, 32'd1, 12'd3, 7'd0, 1'b0);
        add_row(fcss_pkg::MODE_ADVANCE, 13'd0, 8'd0, 12'd0, 1'b1, 32'd2, 12'd4, 7'd0, 1'b0);
        add_row(fcss_pkg::MODE_ADVANCE, 13'd0, 8'd0, 12'd0, 1'b1, 32'd0, 12'hFFF, 7'd0, 1'b1);
        // advance on an ended chain changes nothing
        add_row(fcss_pkg::MODE_ADVANCE, 13'd0, 8'd0, 12'd0, 1'b1, 32'd0, 12'hFFF, 7'd0, 1'b1);
        // open at the extremes and around the end marker
        add_row(fcss_pkg::MODE_OPEN_CHAIN, 13'd0, 8'd0, 12'd0, 1'b1, 32'hFFFF_FFFE, 12'd0,
                7'd0, 1'b0);
        add_row(fcss_pkg::MODE_OPEN_CHAIN, 13'd0, 8'd0, 12'hFFF, 1'b1, 32'd0, 12'hFFF,
                7'd0, 1'b1);
        add_row(fcss_pkg::MODE_OPEN_CHAIN, 13'd0, 8'd0, 12'hFF8, 1'b1, 32'd0, 12'hFF8,
                7'd0, 1'b1);
        add_row(fcss_pkg::MODE_OPEN_CHAIN, 13'd0, 8'd0, 12'hFF7, 1'b1, 32'hFF5, 12'hFF7,
                7'd0, 1'b0);
        // root region
        add_row(fcss_pkg::MODE_OPEN_ROOT, 13'd0, 8'd0, 12'd0, 1'b1, 32'd0, 12'd0, 7'd0, 1'b0);
        add_row(fcss_pkg::MODE_ADVANCE, 13'd0, 8'd0, 12'd0, 1'b1, 32'd1, 12'd0, 7'd0, 1'b0);
        // top address and alternating bits
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'h1FFF, 8'hFF, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'h0AAA, 8'h55, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_WRITE_BYTE, 13'h1555, 8'hAA, 12'd0, 1'b0, 0, 0, 0, 0);
        // odd cluster entry, then back through cluster 0
        add_row(fcss_pkg::MODE_OPEN_CHAIN, 13'd0, 8'd0, 12'd1, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_ADVANCE, 13'd0, 8'd0, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_ADVANCE, 13'd0, 8'd0, 12'd0, 1'b0, 0, 0, 0, 0);
        add_row(fcss_pkg::MODE_OPEN_CHAIN, 13'd0, 8'd0, 12'hAAA, 1'b0, 0, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests
        idle_pct = 14;
        for (int i = 0; i < directed_rows.size(); i++)
            run_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_idle();
            idle_pct = (ph < 3) ? 14 : ((ph < 6) ? 55 : 0);
            case (ph)
                0: load_config(8'd1, 32'd0, 32'hFFFF_FFFF);
                1: load_config(fcss_pkg::MAX_SPC, 32'hFFFF_FFFF, $urandom);
                2: load_config(8'd0, $urandom, 32'd0);
                3: load_config(8'hFF, $urandom, $urandom);
                4: load_config(8'($urandom_range(2, 8)), $urandom, 32'hFFFF_FFF0);
                5: load_config(8'($urandom_range(1, 4)), $urandom, $urandom);
                6: load_config(8'($urandom_range(1, 128)), 32'd0, $urandom);
                default: load_config(8'd3, $urandom, $urandom);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                begin
                    r = random_req(fcss_pkg::MODE_OPEN_CHAIN);
                    lc = 12'($urandom_range(9));
                    if (lc < 7)
                        r.clust = 12'($urandom_range(63));
                    else if (lc == 9)
                        r.clust = fcss_pkg::END_MARK + 12'($urandom_range(7));
                    run_request(r, 1'b0, '0);
                end
                else if (pick < 9)
                    run_request(random_req(fcss_pkg::MODE_OPEN_ROOT), 1'b0, '0);
                else if (pick < 16)
                begin
                    r = random_req(fcss_pkg::MODE_WRITE_BYTE);
                    if ($urandom_range(9) < 7)
                        r.addr = 13'($urandom_range(127));
                    run_request(r, 1'b0, '0);
                end
                else if (pick < 26)
                begin
                    lc = (in_root || chain_done) ? 12'($urandom_range(63)) : cur_cluster;
                    set_entry(lc, pick_link());
                end
                else
                    run_request(random_req(fcss_pkg::MODE_ADVANCE), 1'b0, '0);
            end
        end

        wait_idle();
        $display("ran %0d requests, checked %0d sector results, %0d of them at end of chain",
                 n_requests, n_checked, n_ended);
        $display("settings swept cluster sizes 0, 1, small, 128 and 255 with edge and random bases");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
